/* src/utfrv_pkg.sv */
// Package for the UTF-16 row validator: status codes, surrogate bounds,
// register indexes and the structs shared between the modules.
// Depends on nothing.
`default_nettype none
package utfrv_pkg;

   localparam int UNIT_W     = 16;
   localparam int SCALAR_W   = 8;
   localparam int ROWS_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int MAX_ROWS_DEFAULT = 8;

   localparam logic [UNIT_W-1:0] UNIT_NEWLINE = 16'h000A;
   localparam logic [UNIT_W-1:0] HIGH_FIRST   = 16'hD800;
   localparam logic [UNIT_W-1:0] HIGH_LAST    = 16'hDBFF;
   localparam logic [UNIT_W-1:0] LOW_FIRST    = 16'hDC00;
   localparam logic [UNIT_W-1:0] LOW_LAST     = 16'hDFFF;

   localparam logic [SCALAR_W-1:0] MIN_SCALARS_RESET = 8'd2;
   localparam logic [SCALAR_W-1:0] MAX_SCALARS_RESET = 8'd128;
   localparam logic [SCALAR_W-1:0] SCALAR_SAT        = 8'hFF;
   localparam logic [ROWS_W-1:0]   ROWS_SAT          = 4'hF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_SCALARS = 2'd0,
      CSR_MAX_SCALARS = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_EMPTY_ROW     = 3'd1,
      STATUS_BAD_SURROGATE = 3'd2,
      STATUS_SCALAR_BOUNDS = 3'd3,
      STATUS_ROW_MISMATCH  = 3'd4
   } status_type;

   typedef struct packed {
      logic [SCALAR_W-1:0] min_scalars;
      logic [SCALAR_W-1:0] max_scalars;
   } cfg_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              unit_present;
      logic              region_end;
      logic [ROWS_W-1:0] expected_rows;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic [ROWS_W-1:0] rows_found;
   } result_type;

endpackage
`default_nettype wire

/* src/utfrv_csr.sv */
// Configuration registers of the UTF-16 row validator (scalar bounds).
// Depends on utfrv_pkg.
`default_nettype none
module utfrv_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [utfrv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [utfrv_pkg::CSR_DATA_W-1:0]    csr_data,
   output utfrv_pkg::cfg_type                       cfg
);

   logic [utfrv_pkg::SCALAR_W-1:0] min_ff, min_in;
   logic [utfrv_pkg::SCALAR_W-1:0] max_ff, max_in;

   assign csr_ready = 1'b1;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_valid) begin
         case (csr_index)
            utfrv_pkg::CSR_MIN_SCALARS: min_in = csr_data;
            utfrv_pkg::CSR_MAX_SCALARS: max_in = csr_data;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= utfrv_pkg::MIN_SCALARS_RESET;
         max_ff <= utfrv_pkg::MAX_SCALARS_RESET;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign cfg.min_scalars = min_ff;
   assign cfg.max_scalars = max_ff;

endmodule
`default_nettype wire

/* src/utfrv_row_check.sv */
// Row state and per-unit update of the UTF-16 row validator: surrogate
// pairing, scalar and row tallies, sticky first error, region status.
// Depends on utfrv_pkg.
`default_nettype none
module utfrv_row_check #(
   parameter int MAX_ROWS = utfrv_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  utfrv_pkg::item_type       item,
   input  utfrv_pkg::cfg_type        cfg,
   output utfrv_pkg::result_type     result
);

   localparam logic [utfrv_pkg::ROWS_W-1:0] MaxRows = utfrv_pkg::ROWS_W'(MAX_ROWS);

   logic                             pending_high_ff, pending_high_in;
   logic                             row_nonempty_ff, row_nonempty_in;
   logic                             row_bad_ff, row_bad_in;
   logic [utfrv_pkg::SCALAR_W-1:0]   scalar_tally_ff, scalar_tally_in;
   logic                             scalar_over_ff, scalar_over_in;
   logic [utfrv_pkg::ROWS_W-1:0]     row_tally_ff, row_tally_in;
   logic                             rows_over_ff, rows_over_in;
   utfrv_pkg::status_type            first_error_ff, first_error_in;
   utfrv_pkg::status_type            code;
   utfrv_pkg::status_type            status;
   logic                             is_high, is_low, take_scalar;

   always_comb begin
      pending_high_in = pending_high_ff;
      row_nonempty_in = row_nonempty_ff;
      row_bad_in      = row_bad_ff;
      scalar_tally_in = scalar_tally_ff;
      scalar_over_in  = scalar_over_ff;
      row_tally_in    = row_tally_ff;
      rows_over_in    = rows_over_ff;
      first_error_in  = first_error_ff;
      code            = utfrv_pkg::STATUS_OK;
      status          = utfrv_pkg::STATUS_OK;
      is_high = item.code_unit inside {[utfrv_pkg::HIGH_FIRST:utfrv_pkg::HIGH_LAST]};
      is_low  = item.code_unit inside {[utfrv_pkg::LOW_FIRST:utfrv_pkg::LOW_LAST]};
      take_scalar = 1'b0;

      if (item.unit_present) begin
         if (item.code_unit == utfrv_pkg::UNIT_NEWLINE) begin
            // close the row; later rows are ignored once an error sticks
            if (first_error_ff == utfrv_pkg::STATUS_OK) begin
               if (!row_nonempty_ff)
                  code = utfrv_pkg::STATUS_EMPTY_ROW;
               else if (row_bad_ff || pending_high_ff)
                  code = utfrv_pkg::STATUS_BAD_SURROGATE;
               else if (scalar_over_ff || scalar_tally_ff < cfg.min_scalars ||
                        scalar_tally_ff > cfg.max_scalars)
                  code = utfrv_pkg::STATUS_SCALAR_BOUNDS;
               if (code != utfrv_pkg::STATUS_OK) begin
                  first_error_in = code;
               end else begin
                  if (row_tally_ff >= MaxRows)
                     rows_over_in = 1'b1;
                  if (row_tally_ff != utfrv_pkg::ROWS_SAT)
                     row_tally_in = row_tally_ff + 1'b1;
               end
            end
            pending_high_in = 1'b0;
            row_nonempty_in = 1'b0;
            row_bad_in      = 1'b0;
            scalar_tally_in = '0;
            scalar_over_in  = 1'b0;
         end else begin
            row_nonempty_in = 1'b1;
            if (pending_high_ff && is_low) begin
               // low half completes the pair, already counted
               pending_high_in = 1'b0;
            end else begin
               if (pending_high_ff)
                  row_bad_in = 1'b1;
               pending_high_in = is_high;
               if (is_low)
                  row_bad_in = 1'b1;
               take_scalar = 1'b1;
            end
            if (take_scalar) begin
               if (scalar_tally_ff == utfrv_pkg::SCALAR_SAT)
                  scalar_over_in = 1'b1;
               else
                  scalar_tally_in = scalar_tally_ff + 1'b1;
            end
         end
      end

      if (item.expected_rows == '0)
         status = utfrv_pkg::STATUS_OK;
      else if (first_error_in != utfrv_pkg::STATUS_OK)
         status = first_error_in;
      else if (rows_over_in || item.expected_rows > MaxRows ||
               row_tally_in != item.expected_rows)
         status = utfrv_pkg::STATUS_ROW_MISMATCH;

      result.status     = status;
      result.rows_found = row_tally_in;

      if (item.region_end) begin
         pending_high_in = 1'b0;
         row_nonempty_in = 1'b0;
         row_bad_in      = 1'b0;
         scalar_tally_in = '0;
         scalar_over_in  = 1'b0;
         row_tally_in    = '0;
         rows_over_in    = 1'b0;
         first_error_in  = utfrv_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_high_ff <= 1'b0;
         row_nonempty_ff <= 1'b0;
         row_bad_ff      <= 1'b0;
         scalar_tally_ff <= '0;
         scalar_over_ff  <= 1'b0;
         row_tally_ff    <= '0;
         rows_over_ff    <= 1'b0;
         first_error_ff  <= utfrv_pkg::STATUS_OK;
      end else if (advance) begin
         pending_high_ff <= pending_high_in;
         row_nonempty_ff <= row_nonempty_in;
         row_bad_ff      <= row_bad_in;
         scalar_tally_ff <= scalar_tally_in;
         scalar_over_ff  <= scalar_over_in;
         row_tally_ff    <= row_tally_in;
         rows_over_ff    <= rows_over_in;
         first_error_ff  <= first_error_in;
      end
   end

endmodule
`default_nettype wire

/* src/utf16_row_validator.sv */
// UTF-16 row validator.
// req_ channel: one transaction per code unit (code_unit, unit_present,
//   region_end, expected_rows). An item with region_end set closes the
//   region; with unit_present clear it carries no unit.
// rsp_ channel: one transaction per region, on its region_end item, with
//   status (0 ok, 1 empty row, 2 bad surrogate, 3 scalar bounds, 4 row count
//   mismatch) and rows_found. Other items give no transaction.
// csr_ channel: index 0 writes min_scalars, index 1 max_scalars; other
//   indexes are dropped. Write only while the block is idle.
// Pipeline: an input register, then one pass of row logic into the result
//   register. rsp_valid rises once the region_end item leaves the input
//   register and its result is registered. Throughput is one code unit per
//   cycle while no region_end item is held back by a waiting result, set by the single state update in the row logic.
// Stall: while a result waits on rsp_ready, units that give no result keep
//   flowing; a second region_end item holds in the input register, and
//   req_ready drops only then.
// Reset: clears both pipeline valids and the row state, and loads
//   min_scalars 2 and max_scalars 128.
// Depends on utfrv_pkg, utfrv_csr, utfrv_row_check.
`default_nettype none
module utf16_row_validator #(
   parameter int MAX_ROWS = utfrv_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [utfrv_pkg::UNIT_W-1:0]      req_code_unit,
   input  wire logic                              req_unit_present,
   input  wire logic                              req_region_end,
   input  wire logic [utfrv_pkg::ROWS_W-1:0]      req_expected_rows,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [utfrv_pkg::ROWS_W-1:0]           rsp_rows_found,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [utfrv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [utfrv_pkg::CSR_DATA_W-1:0]  csr_data
);

   utfrv_pkg::cfg_type     cfg;
   utfrv_pkg::item_type    item_ff, item_in;
   utfrv_pkg::result_type  result;
   utfrv_pkg::result_type  rsp_ff;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   advance, req_fire;

   utfrv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   utfrv_row_check #(
      .MAX_ROWS (MAX_ROWS)
   ) u_row_check (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // a held item moves on unless it makes a result that has nowhere to go
   assign advance   = in_valid_ff && (!item_ff.region_end || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in.code_unit     = req_code_unit;
      item_in.unit_present  = req_unit_present;
      item_in.region_end    = req_region_end;
      item_in.expected_rows = req_expected_rows;
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && item_ff.region_end)
         out_valid_in = 1'b1;
      else if (rsp_ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         item_ff <= item_in;
      if (advance && item_ff.region_end)
         rsp_ff <= result;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_rows_found = rsp_ff.rows_found;

endmodule
`default_nettype wire

/* dv/utfrv_row_checker.sv */
// Scoreboard for the UTF-16 row validator: follows the row and region state
// from the req_ and csr_ transactions and checks every rsp_ transaction.
// Depends on utfrv_pkg.
module utfrv_row_checker #(
   parameter int MAX_ROWS = utfrv_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [utfrv_pkg::UNIT_W-1:0]      req_code_unit,
   input  wire logic                              req_unit_present,
   input  wire logic                              req_region_end,
   input  wire logic [utfrv_pkg::ROWS_W-1:0]      req_expected_rows,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [2:0]                        rsp_status,
   input  wire logic [utfrv_pkg::ROWS_W-1:0]      rsp_rows_found,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [utfrv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [utfrv_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                     mismatch_count,
   output int                                     reports_due
);
   import utfrv_pkg::*;

   cfg_type                 bounds;
   logic                    pending_high;
   logic                    row_nonempty;
   logic                    row_bad_surrogate;
   logic [SCALAR_W-1:0]     scalar_tally;
   logic                    scalar_over;
   logic [ROWS_W-1:0]       row_tally;
   logic                    rows_over;
   status_type              first_error;
   result_type              region_status_due[$];

   initial begin
      mismatch_count = 0;
      reports_due = 0;
   end

   function automatic logic is_high(input logic [UNIT_W-1:0] unit);
      return unit >= HIGH_FIRST && unit <= HIGH_LAST;
   endfunction

   function automatic logic is_low(input logic [UNIT_W-1:0] unit);
      return unit >= LOW_FIRST && unit <= LOW_LAST;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t: mismatch, %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_row();
      pending_high = 1'b0;
      row_nonempty = 1'b0;
      row_bad_surrogate = 1'b0;
      scalar_tally = '0;
      scalar_over = 1'b0;
   endfunction

   function automatic void clear_region();
      clear_row();
      row_tally = '0;
      rows_over = 1'b0;
      first_error = STATUS_OK;
   endfunction

   // Once an error sticks, later rows are neither checked nor counted.
   function automatic void close_row();
      status_type code;
      code = STATUS_OK;
      if (first_error == STATUS_OK) begin
         if (!row_nonempty)
            code = STATUS_EMPTY_ROW;
         else if (row_bad_surrogate || pending_high)
            code = STATUS_BAD_SURROGATE;
         else if (scalar_over || scalar_tally < bounds.min_scalars ||
                  scalar_tally > bounds.max_scalars)
            code = STATUS_SCALAR_BOUNDS;
         if (code != STATUS_OK) begin
            first_error = code;
         end else begin
            if (row_tally >= MAX_ROWS)
               rows_over = 1'b1;
            if (row_tally != ROWS_SAT)
               row_tally = row_tally + 1'b1;
         end
      end
      clear_row();
   endfunction

   function automatic void fold_unit(input logic [UNIT_W-1:0] unit);
      logic paired;
      paired = 1'b0;
      if (unit == UNIT_NEWLINE) begin
         close_row();
      end else begin
         row_nonempty = 1'b1;
         if (pending_high) begin
            pending_high = 1'b0;
            if (is_low(unit))
               paired = 1'b1;
            else
               row_bad_surrogate = 1'b1;
         end
         if (!paired) begin
            if (is_high(unit))
               pending_high = 1'b1;
            else if (is_low(unit))
               row_bad_surrogate = 1'b1;
            if (scalar_tally == SCALAR_SAT)
               scalar_over = 1'b1;
            else
               scalar_tally = scalar_tally + 1'b1;
         end
      end
   endfunction

   function automatic void close_region(input logic [ROWS_W-1:0] rows_claim);
      result_type report;
      if (rows_claim == 0)
         report.status = STATUS_OK;
      else if (first_error != STATUS_OK)
         report.status = first_error;
      else if (rows_over || rows_claim > MAX_ROWS || row_tally != rows_claim)
         report.status = STATUS_ROW_MISMATCH;
      else
         report.status = STATUS_OK;
      report.rows_found = row_tally;
      // append at the tail of the queue
      region_status_due = {region_status_due, report};
      clear_region();
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         bounds.min_scalars = MIN_SCALARS_RESET;
         bounds.max_scalars = MAX_SCALARS_RESET;
         clear_region();
         region_status_due.delete();
      end else begin
         // Compare first: a result can never belong to an item taken this edge.
         if (rsp_valid && rsp_ready) begin
            if (region_status_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result, status=%0d rows_found=%0d",
                                       rsp_status, rsp_rows_found));
            end else begin
               want = region_status_due.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("rsp_status got %0d want %0d",
                                          rsp_status, want.status));
               if (rsp_rows_found !== want.rows_found)
                  flag_mismatch($sformatf("rsp_rows_found got %0d want %0d",
                                          rsp_rows_found, want.rows_found));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_SCALARS: bounds.min_scalars = csr_data;
               CSR_MAX_SCALARS: bounds.max_scalars = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_unit_present)
               fold_unit(req_code_unit);
            if (req_region_end)
               close_region(req_expected_rows);
         end
      end
      reports_due = region_status_due.size();
   end

endmodule

/* dv/utf16_row_validator_tb.sv */
// Top of the UTF-16 row validator testbench: clock, reset, stimulus on the
// req_, rsp_ and csr_ channels, watchdog and verdict.
// Depends on utfrv_pkg, utf16_row_validator and utfrv_row_checker.
module utf16_row_validator_tb;
   import utfrv_pkg::*;

   localparam int MAX_ROWS = MAX_ROWS_DEFAULT;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [UNIT_W-1:0] UNIT_LETTER_A = 16'h0041;
   localparam logic [UNIT_W-1:0] UNIT_LETTER_B = 16'h0042;
   localparam logic [UNIT_W-1:0] UNIT_ZERO = 16'h0000;
   localparam logic [UNIT_W-1:0] UNIT_ALL_ONES = 16'hFFFF;

   typedef enum int {
      FLAW_NONE,
      FLAW_LONE_LOW,
      FLAW_UNPAIRED_HIGH,
      FLAW_HIGH_AT_END,
      FLAW_NOISE
   } row_flaw_type;

   typedef enum int {
      END_ON_NEWLINE,
      END_ON_TAIL,
      END_BY_MARKER
   } region_close_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [UNIT_W-1:0]      req_code_unit = '0;
   logic                   req_unit_present = 1'b0;
   logic                   req_region_end = 1'b0;
   logic [ROWS_W-1:0]      req_expected_rows = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_status;
   logic [ROWS_W-1:0]      rsp_rows_found;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_count;
   int reports_due;
   int send_idle_pct = 10;
   int recv_idle_pct = 55;
   int items_sent = 0;
   int shaping_min = MIN_SCALARS_RESET;
   int shaping_max = MAX_SCALARS_RESET;
   int stall_cycles = 0;
   int min_plan[PHASES] = '{1, 3, 0, 9, 255, 2, 1, 5};
   int max_plan[PHASES] = '{255, 6, 0, 4, 255, 128, 1, 12};

   utf16_row_validator #(.MAX_ROWS(MAX_ROWS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_code_unit(req_code_unit),
      .req_unit_present(req_unit_present),
      .req_region_end(req_region_end),
      .req_expected_rows(req_expected_rows),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_rows_found(rsp_rows_found),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   utfrv_row_checker #(.MAX_ROWS(MAX_ROWS)) row_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_code_unit(req_code_unit),
      .req_unit_present(req_unit_present),
      .req_region_end(req_region_end),
      .req_expected_rows(req_expected_rows),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_rows_found(rsp_rows_found),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count),
      .reports_due(reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [UNIT_W-1:0] high_unit();
      return HIGH_FIRST + UNIT_W'($urandom_range(HIGH_LAST - HIGH_FIRST));
   endfunction

   function automatic logic [UNIT_W-1:0] low_unit();
      return LOW_FIRST + UNIT_W'($urandom_range(LOW_LAST - LOW_FIRST));
   endfunction

   // Any unit but a newline, surrogates included.
   function automatic logic [UNIT_W-1:0] noise_unit();
      logic [UNIT_W-1:0] unit;
      unit = UNIT_W'($urandom);
      if (unit == UNIT_NEWLINE)
         unit = unit | 16'h0100;
      return unit;
   endfunction

   // A unit that is one scalar on its own: fold newline and surrogates away.
   function automatic logic [UNIT_W-1:0] plain_unit();
      logic [UNIT_W-1:0] unit;
      unit = noise_unit();
      if (unit >= HIGH_FIRST && unit <= LOW_LAST)
         unit = unit ^ 16'h2000;
      return unit;
   endfunction

   function automatic int pick_scalars();
      int roll;
      int lo;
      int hi;
      roll = $urandom_range(99);
      lo = (shaping_min > 1) ? shaping_min : 1;
      hi = (shaping_max < 12) ? shaping_max : 12;
      if (roll < 4)
         return 0;
      if (roll < 10 && (shaping_max >= 200 || shaping_min >= 200))
         return $urandom_range(258, 250);
      if (roll < 85 && lo <= hi)
         return $urandom_range(hi, lo);
      return $urandom_range(14, 1);
   endfunction

   // Called and returns at a falling edge; valid stays high into the next call.
   task automatic push_unit(input logic [UNIT_W-1:0] unit, input logic present,
                            input logic last, input logic [ROWS_W-1:0] rows_claim);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_unit <= unit;
      req_unit_present <= present;
      req_region_end <= last;
      req_expected_rows <= rows_claim;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (present || last)
         items_sent++;
   endtask

   task automatic push_mid(input logic [UNIT_W-1:0] unit);
      push_unit(unit, 1'b1, 1'b0, ROWS_W'($urandom_range(15)));
   endtask

   task automatic send_row_body(input int scalars, input row_flaw_type flaw);
      int spot;
      spot = $urandom_range(scalars, 0);
      for (int i = 0; i <= scalars; i++) begin
         if (i == spot) begin
            case (flaw)
               FLAW_LONE_LOW:      push_mid(low_unit());
               FLAW_UNPAIRED_HIGH: push_mid(high_unit());
               default: ;
            endcase
         end
         if (i < scalars) begin
            if (flaw == FLAW_NOISE) begin
               push_mid(noise_unit());
            end else if ($urandom_range(3) == 0) begin
               push_mid(high_unit());
               push_mid(low_unit());
            end else begin
               push_mid(plain_unit());
            end
         end
      end
      if (flaw == FLAW_HIGH_AT_END)
         push_mid(high_unit());
   endtask

   task automatic send_region();
      int rows;
      logic [ROWS_W-1:0] rows_claim;
      region_close_type closing;
      row_flaw_type flaw;
      rows = ($urandom_range(99) < 10) ? $urandom_range(17, 9) : $urandom_range(5, 1);
      rows_claim = ($urandom_range(99) < 70) ? ROWS_W'(rows) : ROWS_W'($urandom_range(15));
      closing = region_close_type'($urandom_range(END_BY_MARKER, END_ON_NEWLINE));
      for (int r = 0; r < rows; r++) begin
         flaw = ($urandom_range(99) < 80) ? FLAW_NONE :
                row_flaw_type'($urandom_range(FLAW_NOISE, FLAW_LONE_LOW));
         send_row_body(pick_scalars(), flaw);
         if (r == rows - 1 && closing == END_ON_NEWLINE)
            push_unit(UNIT_NEWLINE, 1'b1, 1'b1, rows_claim);
         else
            push_mid(UNIT_NEWLINE);
         // Sprinkle items that carry nothing.
         if ($urandom_range(99) < 8)
            push_unit(noise_unit(), 1'b0, 1'b0, ROWS_W'($urandom_range(15)));
      end
      if (closing == END_ON_TAIL) begin
         repeat ($urandom_range(3))
            push_mid(noise_unit());
         push_unit(noise_unit(), 1'b1, 1'b1, rows_claim);
      end else if (closing == END_BY_MARKER) begin
         push_unit(UNIT_W'($urandom), 1'b0, 1'b1, rows_claim);
      end
   endtask

   // Hold the sender until every result is back, then let the pipe drain.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (reports_due != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_goal;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset bounds 2..128: field extremes, both surrogate pairs, good region.
      push_mid(UNIT_ZERO);
      push_mid(UNIT_ALL_ONES);
      push_mid(UNIT_NEWLINE);
      push_mid(HIGH_FIRST);
      push_mid(LOW_FIRST);
      push_mid(HIGH_LAST);
      push_mid(LOW_LAST);
      push_unit(UNIT_NEWLINE, 1'b1, 1'b1, 4'd2);
      // Empty region closed by a marker, after an item that carries nothing.
      push_unit(UNIT_ALL_ONES, 1'b0, 1'b0, 4'd15);
      push_unit(UNIT_ZERO, 1'b0, 1'b1, 4'd0);
      // Empty row.
      push_unit(UNIT_NEWLINE, 1'b1, 1'b1, 4'd1);
      // Empty row, but no row count claimed.
      push_unit(UNIT_NEWLINE, 1'b1, 1'b1, 4'd0);
      // Lone low surrogate.
      push_mid(LOW_FIRST);
      push_mid(UNIT_LETTER_A);
      push_unit(UNIT_NEWLINE, 1'b1, 1'b1, 4'd1);
      // High surrogate at row end wins over a bad claim.
      push_mid(UNIT_LETTER_A);
      push_mid(HIGH_LAST);
      push_unit(UNIT_NEWLINE, 1'b1, 1'b1, 4'd15);
      // Too few scalars; the tail is dropped.
      push_mid(UNIT_LETTER_A);
      push_mid(UNIT_NEWLINE);
      push_unit(UNIT_LETTER_B, 1'b1, 1'b1, 4'd1);
      // Claim above the row limit.
      push_mid(UNIT_LETTER_A);
      push_mid(UNIT_LETTER_B);
      push_mid(UNIT_NEWLINE);
      push_unit(LOW_LAST, 1'b1, 1'b1, 4'd9);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 10;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         settle_block();
         if (p == 0)
            write_register(CSR_SPARE_INDEX, CSR_DATA_W'($urandom_range(255)));
         write_register(CSR_MIN_SCALARS, CSR_DATA_W'(min_plan[p]));
         write_register(CSR_MAX_SCALARS, CSR_DATA_W'(max_plan[p]));
         csr_valid <= 1'b0;
         shaping_min = min_plan[p];
         shaping_max = max_plan[p];
         phase_goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_goal)
            send_region();
      end

      settle_block();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
